// ===== rtl/two_stack_text_buffer_defines.svh =====
// assertion macros shared by the text buffer rtl
`ifndef TWO_STACK_TEXT_BUFFER_DEFINES_SVH
`define TWO_STACK_TEXT_BUFFER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TSTB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define TSTB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tstb_pkg.sv =====
// shared types, codes and helpers of the text buffer
package tstb_pkg;

    localparam int ACT_W  = 4;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 10;
    localparam int CNT_W  = 11;
    localparam int STAT_W = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT    = 4'd0,
        ACT_DELETE    = 4'd1,
        ACT_FWD       = 4'd2,
        ACT_BACK      = 4'd3,
        ACT_START     = 4'd4,
        ACT_END       = 4'd5,
        ACT_NEXT_WORD = 4'd6,
        ACT_PREV_WORD = 4'd7,
        ACT_DEL_WORD  = 4'd8,
        ACT_READ      = 4'd9
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    localparam logic [CHAR_W-1:0] SEP_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] SEP_PERIOD = 8'h2E;
    localparam logic [CHAR_W-1:0] SEP_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] SEP_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] SEP_COLON  = 8'h3A;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CHAR_W-1:0] char_in;
        logic [POS_W-1:0]  position;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]  cursor;
        logic [CNT_W-1:0]  length;
        logic [CHAR_W-1:0] char_out;
        t_status           status;
    } t_result;

    // word boundary characters
    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        return (c == SEP_SPACE) || (c == SEP_PERIOD) || (c == SEP_COMMA) ||
               (c == SEP_SEMI) || (c == SEP_COLON);
    endfunction

endpackage

// ===== rtl/tstb_if.sv =====
// edit command and result channel interfaces
interface tstb_in_if;
    logic                        valid;
    logic                        ready;
    logic [tstb_pkg::ACT_W-1:0]  action;
    logic [tstb_pkg::CHAR_W-1:0] char_in;
    logic [tstb_pkg::POS_W-1:0]  position;

    modport source (output valid, action, char_in, position, input ready);
    modport sink   (input valid, action, char_in, position, output ready);
endinterface

interface tstb_out_if;
    logic                        valid;
    logic                        ready;
    logic [tstb_pkg::CNT_W-1:0]  cursor;
    logic [tstb_pkg::CNT_W-1:0]  length;
    logic [tstb_pkg::CHAR_W-1:0] char_out;
    logic [tstb_pkg::STAT_W-1:0] status;

    modport source (output valid, cursor, length, char_out, status, input ready);
    modport sink   (input valid, cursor, length, char_out, status, output ready);
endinterface

// ===== rtl/tstb_ram.sv =====
// generic single-write, single-read ram with registered read data
module tstb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tstb_ctrl.sv =====
// edit sequencer: stack counts, both stack rams and the one-char move step
`include "two_stack_text_buffer_defines.svh"

module tstb_ctrl #(
    parameter int CAPACITY = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tstb_pkg::t_cmd    i_cmd,
    input  logic              i_res_free,
    output logic              o_ready,
    output logic              o_done,
    output tstb_pkg::t_result o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int TW = CW + 1;
    localparam int XW = ((CW > tstb_pkg::POS_W) ? CW : tstb_pkg::POS_W) + 1;
    localparam int OW = tstb_pkg::CNT_W;
    localparam int DW = tstb_pkg::CHAR_W;
    localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_MOVE_RD = 6'b000100,
        S_MOVE    = 6'b001000,
        S_READ    = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    tstb_pkg::t_action   r_act, n_act;
    tstb_pkg::t_status   r_status, n_status;
    logic [DW-1:0]       r_char, n_char;
    logic [DW-1:0]       r_rd, n_rd;
    logic [tstb_pkg::POS_W-1:0] r_pos, n_pos;
    logic [CW-1:0]       r_bcnt, n_bcnt;
    logic [CW-1:0]       r_acnt, n_acnt;
    logic                r_fwd, n_fwd;
    logic                r_word, n_word;
    logic                r_single, n_single;
    logic                r_keep, n_keep;
    logic                r_rsel, n_rsel;

    logic          b_we, a_we;
    logic [AW-1:0] b_waddr, a_waddr, b_raddr, a_raddr;
    logic [DW-1:0] b_wdata, a_wdata, b_rdata, a_rdata;

    logic [TW-1:0] w_total;
    logic [CW-1:0] w_src, w_src_m1, w_src_m2;
    logic [DW-1:0] w_sdata;
    logic [XW-1:0] w_pos_x, w_bcnt_x, w_total_x, w_aidx;

    assign w_total   = TW'(r_bcnt) + TW'(r_acnt);
    assign w_src     = r_fwd ? r_acnt : r_bcnt;
    assign w_src_m1  = w_src - CW'(1);
    assign w_src_m2  = w_src - CW'(2);
    assign w_sdata   = r_fwd ? a_rdata : b_rdata;
    assign w_pos_x   = XW'(r_pos);
    assign w_bcnt_x  = XW'(r_bcnt);
    assign w_total_x = XW'(w_total);
    // after stack is stored top-last: text index maps to total - 1 - pos
    assign w_aidx    = w_total_x - XW'(1) - w_pos_x;

    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_status = r_status;
        n_char   = r_char;
        n_rd     = r_rd;
        n_pos    = r_pos;
        n_bcnt   = r_bcnt;
        n_acnt   = r_acnt;
        n_fwd    = r_fwd;
        n_word   = r_word;
        n_single = r_single;
        n_keep   = r_keep;
        n_rsel   = r_rsel;
        b_we     = 1'b0;
        a_we     = 1'b0;
        b_waddr  = r_bcnt[AW-1:0];
        a_waddr  = r_acnt[AW-1:0];
        b_wdata  = w_sdata;
        a_wdata  = w_sdata;
        b_raddr  = w_src_m1[AW-1:0];
        a_raddr  = w_src_m1[AW-1:0];
        o_ready  = 1'b0;
        o_done   = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_act    = tstb_pkg::t_action'(i_cmd.action);
                    n_char   = i_cmd.char_in;
                    n_pos    = i_cmd.position;
                    n_rd     = '0;
                    n_status = tstb_pkg::ST_OK;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state  = S_DONE;
                n_fwd    = 1'b1;
                n_word   = 1'b0;
                n_single = 1'b0;
                n_keep   = 1'b1;
                n_rsel   = 1'b1;
                case (r_act)
                    tstb_pkg::ACT_INSERT: begin
                        if (w_total >= CAP_T) begin
                            n_status = tstb_pkg::ST_FULL;
                        end else begin
                            b_we    = 1'b1;
                            b_waddr = r_bcnt[AW-1:0];
                            b_wdata = r_char;
                            n_bcnt  = r_bcnt + CW'(1);
                        end
                    end
                    tstb_pkg::ACT_DELETE: begin
                        if (r_acnt != '0) begin
                            n_acnt = r_acnt - CW'(1);
                        end
                    end
                    tstb_pkg::ACT_FWD: begin
                        n_single = 1'b1;
                        n_state  = S_MOVE_RD;
                    end
                    tstb_pkg::ACT_BACK: begin
                        n_fwd    = 1'b0;
                        n_single = 1'b1;
                        n_state  = S_MOVE_RD;
                    end
                    tstb_pkg::ACT_START: begin
                        n_fwd   = 1'b0;
                        n_state = S_MOVE_RD;
                    end
                    tstb_pkg::ACT_END: begin
                        n_state = S_MOVE_RD;
                    end
                    tstb_pkg::ACT_NEXT_WORD: begin
                        n_word  = 1'b1;
                        n_state = S_MOVE_RD;
                    end
                    tstb_pkg::ACT_PREV_WORD: begin
                        n_fwd   = 1'b0;
                        n_word  = 1'b1;
                        n_state = S_MOVE_RD;
                    end
                    tstb_pkg::ACT_DEL_WORD: begin
                        n_word  = 1'b1;
                        n_keep  = 1'b0;
                        n_state = S_MOVE_RD;
                    end
                    tstb_pkg::ACT_READ: begin
                        if (w_pos_x < w_bcnt_x) begin
                            b_raddr = w_pos_x[AW-1:0];
                            n_rsel  = 1'b1;
                            n_state = S_READ;
                        end else if (w_pos_x < w_total_x) begin
                            a_raddr = w_aidx[AW-1:0];
                            n_rsel  = 1'b0;
                            n_state = S_READ;
                        end else begin
                            n_status = tstb_pkg::ST_RANGE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MOVE_RD: begin
                // fetch the top of the source stack, if any
                if (w_src == '0) begin
                    n_state = S_DONE;
                end else begin
                    b_raddr = w_src_m1[AW-1:0];
                    a_raddr = w_src_m1[AW-1:0];
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (r_word && tstb_pkg::is_sep(w_sdata)) begin
                    n_state = S_DONE;
                end else begin
                    if (r_fwd) begin
                        n_acnt = r_acnt - CW'(1);
                        if (r_keep) begin
                            b_we    = 1'b1;
                            b_waddr = r_bcnt[AW-1:0];
                            b_wdata = w_sdata;
                            n_bcnt  = r_bcnt + CW'(1);
                        end
                    end else begin
                        n_bcnt  = r_bcnt - CW'(1);
                        a_we    = 1'b1;
                        a_waddr = r_acnt[AW-1:0];
                        a_wdata = w_sdata;
                        n_acnt  = r_acnt + CW'(1);
                    end
                    // next top is fetched while this one is written
                    if (r_single || (w_src == CW'(1))) begin
                        n_state = S_DONE;
                    end else begin
                        b_raddr = w_src_m2[AW-1:0];
                        a_raddr = w_src_m2[AW-1:0];
                    end
                end
            end
            S_READ: begin
                n_rd    = r_rsel ? b_rdata : a_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bcnt  <= '0;
            r_acnt  <= '0;
        end else begin
            r_state <= n_state;
            r_bcnt  <= n_bcnt;
            r_acnt  <= n_acnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_status <= n_status;
        r_char   <= n_char;
        r_rd     <= n_rd;
        r_pos    <= n_pos;
        r_fwd    <= n_fwd;
        r_word   <= n_word;
        r_single <= n_single;
        r_keep   <= n_keep;
        r_rsel   <= n_rsel;
    end

    tstb_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_before_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    tstb_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_after_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    assign o_res.cursor   = OW'(r_bcnt);
    assign o_res.length   = OW'(w_total);
    assign o_res.char_out = r_rd;
    assign o_res.status   = r_status;

    `TSTB_ASSERT_IMP(a_total_cap, 1'b1, w_total <= CAP_T, "text length beyond capacity")
    `TSTB_ASSERT_IMP(a_move_src, r_state == S_MOVE, w_src != '0, "move step on empty stack")
    `TSTB_ASSERT_NXT(a_move_keeps_len, (r_state == S_MOVE) && r_keep, $stable(w_total), "cursor move changed length")
    `TSTB_ASSERT_IMP(a_full_flag, (r_state == S_DONE) && (r_status == tstb_pkg::ST_FULL), w_total == CAP_T, "full flag with room left")

endmodule

// ===== rtl/two_stack_text_buffer.sv =====
// top level of the two-stack text buffer: command channel, result register, sequencer
//
// i_cmd carries one edit per item: action, char_in (insert only) and position
//   (read only); o_res returns exactly one item per edit with the cursor, the
//   text length, the read character and a status code
// both channels use valid/ready; an item moves when both are high
// from command taken to result valid: insert, delete and unused action codes pass
//   through S_EXEC and S_DONE, a read in range through S_EXEC, S_READ and S_DONE
// cursor moves and word operations step one character per cycle through the
//   shared move unit (S_MOVE_RD, then S_MOVE); a word operation stops at a
//   separator without moving it; the single read port of each stack ram sets the
//   one-character step
// one edit is in flight at a time; i_cmd.ready is high only while the sequencer
//   is idle, so the next edit is taken in the cycle after the result is handed over
// reset: both stack counts go to zero and the text is empty; stack contents are
//   not cleared and need no sweep, since entries are only read below their count
// stall: the result register holds one finished item; a new edit is taken while
//   it waits, and the sequencer holds the next result until the register is free
module two_stack_text_buffer #(
    parameter int CAPACITY = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tstb_in_if.sink       i_cmd,
    tstb_out_if.source    o_res
);

    tstb_pkg::t_cmd    w_cmd;
    tstb_pkg::t_result w_res;
    tstb_pkg::t_result r_res;
    logic              r_out_valid;
    logic              w_ready;
    logic              w_start;
    logic              w_done;
    logic              w_res_free;

    // command payload into the sequencer
    assign w_cmd.action   = i_cmd.action;
    assign w_cmd.char_in  = i_cmd.char_in;
    assign w_cmd.position = i_cmd.position;

    assign i_cmd.ready = w_ready;
    assign w_start     = i_cmd.valid && w_ready;

    // result register is free when empty or being drained this cycle
    assign w_res_free = !r_out_valid || o_res.ready;

    tstb_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_cmd      (w_cmd),
        .i_res_free (w_res_free),
        .o_ready    (w_ready),
        .o_done     (w_done),
        .o_res      (w_res)
    );

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, loaded only when a finished edit is handed over
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.cursor   = r_res.cursor;
    assign o_res.length   = r_res.length;
    assign o_res.char_out = r_res.char_out;
    assign o_res.status   = r_res.status;

endmodule
